// ----- src/fms_pkg.sv -----
// Package for the fuzzy match scorer: widths, register and result codes,
// the control word of the window cells and the final-state struct of the score unit.
// No dependencies; every other file imports it.
package fms_pkg;

  localparam int MAX_QUERY = 16;
  localparam int WIN_DEPTH = MAX_QUERY + 1;
  localparam int QLEN_W = 5;
  localparam int QIDX_W = $clog2(MAX_QUERY);
  localparam int QUERY_W = 8 * MAX_QUERY;
  localparam int CNT_W = 10;
  localparam int SCORE_W = 11;

  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [QLEN_W-1:0] QLEN_MAX = QLEN_W'(MAX_QUERY);

  // Tier tops and floors; each tier is top minus a penalty clamped at top-floor.
  localparam logic signed [SCORE_W-1:0] SCORE_NONE = -11'sd1;
  localparam logic signed [SCORE_W-1:0] SCORE_EXACT = 11'sd1000;
  localparam logic signed [SCORE_W-1:0] TOP_PREFIX = 11'sd800;
  localparam logic signed [SCORE_W-1:0] TOP_BOUND = 11'sd600;
  localparam logic signed [SCORE_W-1:0] TOP_SUBSTR = 11'sd400;
  localparam logic signed [SCORE_W-1:0] TOP_SUBSEQ = 11'sd200;
  localparam logic [CNT_W-1:0] PENALTY_MAX = 10'd199;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_QUERY_LENGTH = 2'd0,
    CFG_QUERY_LOW    = 2'd1,
    CFG_QUERY_HIGH   = 2'd2
  } cfg_reg_t;

  // Match kinds reported with each score.
  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_EXACT    = 3'd1,
    KIND_PREFIX   = 3'd2,
    KIND_BOUNDARY = 3'd3,
    KIND_SUBSTR   = 3'd4,
    KIND_SUBSEQ   = 3'd5
  } kind_t;

  // Control word for the window cells.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Final per-text state handed to the score unit.
  typedef struct packed {
    logic [QLEN_W-1:0] qlen;
    logic [CNT_W-1:0]  byte_count;
    logic              prefix_ok;
    logic              sub_found;
    logic [CNT_W-1:0]  sub_start;
    logic              sub_boundary;
    logic [QLEN_W-1:0] seq_idx;
    logic [CNT_W-1:0]  gap_count;
  } fin_t;

  // Query byte at a given position of the packed query.
  function automatic logic [7:0] qbyte(input logic [QUERY_W-1:0] q,
                                       input logic [QIDX_W-1:0] idx);
    return q[{idx, 3'b000} +: 8];
  endfunction

  // Word boundary characters: / . _ space - :
  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h2F) || (c == 8'h2E) || (c == 8'h5F) || (c == 8'h20) ||
           (c == 8'h2D) || (c == 8'h3A);
  endfunction

endpackage

// ----- src/fms_cell.sv -----
// One window cell: holds one recent text byte and compares the byte it is
// about to take against its aligned query byte. Depends on fms_pkg.
module fms_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fms_pkg::cell_ctl_t ctl,
  input  logic [7:0]         shift_in,
  input  logic [7:0]         q_byte,
  input  logic               q_use,
  output logic [7:0]         byte_out,
  output logic               hit
);
  import fms_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Clear wins over shift so a finished text leaves an empty window.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = 8'd0;
    end else if (ctl.shift) begin
      byte_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // Unused cells always agree.
  assign hit = !q_use || (shift_in == q_byte);
  assign byte_out = byte_r;

endmodule

// ----- src/fms_window.sv -----
// Row of window cells holding the newest text bytes, newest first.
// Reports whether the window after this byte ends in the query. Depends on
// fms_pkg and fms_cell.
module fms_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fms_pkg::cell_ctl_t            ctl,
  input  logic [7:0]                    text_byte,
  input  logic [fms_pkg::QLEN_W-1:0]    qlen,
  input  logic [fms_pkg::QUERY_W-1:0]   query,
  output logic                          hit_all,
  output logic [7:0]                    bnd_byte
);
  import fms_pkg::*;

  logic [7:0]           cell_in  [WIN_DEPTH];
  logic [7:0]           cell_out [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] hits;

  assign cell_in[0] = text_byte;

  // Cell i sees query byte qlen-1-i, so the newest byte meets the last one.
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    logic [7:0]        q_b;
    logic              q_u;

    if (i > 0) begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end

    if (i < MAX_QUERY) begin : g_cmp
      logic [QLEN_W-1:0] pos;
      assign q_u = qlen > QLEN_W'(i);
      assign pos = qlen - QLEN_W'(i + 1);
      assign q_b = qbyte(query, pos[QIDX_W-1:0]);
    end else begin : g_nocmp
      assign q_u = 1'b0;
      assign q_b = 8'd0;
    end

    fms_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_in (cell_in[i]),
      .q_byte   (q_b),
      .q_use    (q_u),
      .byte_out (cell_out[i]),
      .hit      (hits[i])
    );
  end

  assign hit_all = &hits;

  // Byte just before a match of the current length.
  assign bnd_byte = cell_in[qlen];

endmodule

// ----- src/fms_score.sv -----
// Score unit: turns the final state of one text into a tiered score and
// match kind. Depends on fms_pkg.
module fms_score (
  input  fms_pkg::fin_t                    fin,
  output logic signed [fms_pkg::SCORE_W-1:0] score,
  output fms_pkg::kind_t                   kind
);
  import fms_pkg::*;

  logic [CNT_W-1:0]          penalty;
  logic [CNT_W-1:0]          pen_clamped;
  logic signed [SCORE_W-1:0] top;
  logic [CNT_W-1:0]          qlen_ext;

  assign qlen_ext = CNT_W'(fin.qlen);

  // Pick the tier in priority order.
  always_comb begin
    kind    = KIND_NONE;
    top     = SCORE_NONE;
    penalty = '0;
    priority if (fin.qlen == '0 || fin.byte_count == '0) begin
      kind = KIND_NONE;
    end else if (fin.prefix_ok && fin.byte_count == qlen_ext) begin
      kind = KIND_EXACT;
      top  = SCORE_EXACT;
    end else if (fin.prefix_ok && fin.byte_count > qlen_ext) begin
      kind    = KIND_PREFIX;
      top     = TOP_PREFIX;
      penalty = fin.byte_count - qlen_ext;
    end else if (fin.sub_found && fin.sub_boundary) begin
      kind    = KIND_BOUNDARY;
      top     = TOP_BOUND;
      penalty = fin.sub_start;
    end else if (fin.sub_found) begin
      kind    = KIND_SUBSTR;
      top     = TOP_SUBSTR;
      penalty = fin.sub_start;
    end else if (fin.seq_idx >= fin.qlen) begin
      kind    = KIND_SUBSEQ;
      top     = TOP_SUBSEQ;
      penalty = fin.gap_count;
    end else begin
      kind = KIND_NONE;
    end
  end

  // Every tier floors at top minus the same amount.
  assign pen_clamped = (penalty > PENALTY_MAX) ? PENALTY_MAX : penalty;
  assign score = top - $signed({1'b0, pen_clamped});

endmodule

// ----- src/fuzzy_match_score.sv -----
// Fuzzy match scorer top level: streams text bytes against a stored query.
// Throughput is one input word per cycle unless the snapshot stage is stuck;
// the window cells compare all query positions in parallel as each byte
// shifts in. The result of an end-of-text word passes a snapshot register
// and then an output register. Synchronous active-low reset clears the query
// registers, the text state and both result stages' valid flags. Depends on fms_pkg.
module fuzzy_match_score (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_no_byte,
  input  logic                                in_end_of_text,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fms_pkg::SCORE_W-1:0]  out_score,
  output logic [2:0]                          out_match_kind,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [63:0]                         cfg_data
);
  import fms_pkg::*;

  // Configuration registers.
  logic [QLEN_W-1:0]  qlen_r;
  logic [63:0]        qlow_r;
  logic [63:0]        qhigh_r;
  logic [QUERY_W-1:0] query;
  logic [QLEN_W-1:0]  qlen;

  // Per-text state.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              prefix_r, prefix_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic              bound_r, bound_nxt;
  logic [QLEN_W-1:0] sidx_r, sidx_nxt;
  logic [CNT_W-1:0]  gap_r, gap_nxt;

  // Result stages.
  logic                      fin_valid_r;
  fin_t                      fin_r;
  fin_t                      fin_nxt;
  logic                      fin_adv;
  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  kind_t                     out_kind_r;
  logic signed [SCORE_W-1:0] sc_score;
  kind_t                     sc_kind;

  logic       accept;
  logic       take;
  logic       ends;
  cell_ctl_t  ctl;
  logic       win_hit;
  logic [7:0] bnd_byte;
  logic [7:0] pre_q;
  logic [7:0] seq_q;
  logic [CNT_W-1:0] qlen_ext;
  logic [CNT_W-1:0] inc_count;
  logic [CNT_W-1:0] new_start;

  assign cfg_ready = 1'b1;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r  <= '0;
      qlow_r  <= '0;
      qhigh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUERY_LENGTH: qlen_r  <= cfg_data[QLEN_W-1:0];
        CFG_QUERY_LOW:    qlow_r  <= cfg_data;
        CFG_QUERY_HIGH:   qhigh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign query    = {qhigh_r, qlow_r};
  assign qlen     = (qlen_r > QLEN_MAX) ? QLEN_MAX : qlen_r;
  assign qlen_ext = CNT_W'(qlen);

  // Handshake: an input word waits only when the snapshot stage is stuck.
  assign fin_adv  = fin_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !fin_valid_r || fin_adv;
  assign accept   = in_valid && in_ready;
  assign take     = accept && !in_no_byte;
  assign ends     = accept && in_end_of_text;

  assign ctl.shift = take;
  assign ctl.clear = ends;

  fms_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .text_byte (in_text_byte),
    .qlen      (qlen),
    .query     (query),
    .hit_all   (win_hit),
    .bnd_byte  (bnd_byte)
  );

  assign pre_q     = qbyte(query, count_r[QIDX_W-1:0]);
  assign seq_q     = qbyte(query, sidx_r[QIDX_W-1:0]);
  assign inc_count = (count_r == COUNT_MAX) ? count_r : count_r + CNT_W'(1);
  assign new_start = inc_count - qlen_ext;

  // Text state after this word.
  always_comb begin
    count_nxt  = count_r;
    prefix_nxt = prefix_r;
    found_nxt  = found_r;
    start_nxt  = start_r;
    bound_nxt  = bound_r;
    sidx_nxt   = sidx_r;
    gap_nxt    = gap_r;
    if (take) begin
      count_nxt = inc_count;
      if (count_r < qlen_ext && in_text_byte != pre_q) begin
        prefix_nxt = 1'b0;
      end
      // Greedy subsequence: gaps count only after the first matched byte.
      if (sidx_r < qlen) begin
        if (in_text_byte == seq_q) begin
          sidx_nxt = sidx_r + QLEN_W'(1);
        end else if (sidx_r != '0 && gap_r != COUNT_MAX) begin
          gap_nxt = gap_r + CNT_W'(1);
        end
      end
      // First occurrence of the whole query ending at this byte.
      if (!found_r && qlen != '0 && inc_count >= qlen_ext && win_hit) begin
        found_nxt = 1'b1;
        start_nxt = new_start;
        bound_nxt = (new_start == '0) || is_sep(bnd_byte);
      end
    end
  end

  always_comb begin
    fin_nxt.qlen         = qlen;
    fin_nxt.byte_count   = count_nxt;
    fin_nxt.prefix_ok    = prefix_nxt;
    fin_nxt.sub_found    = found_nxt;
    fin_nxt.sub_start    = start_nxt;
    fin_nxt.sub_boundary = bound_nxt;
    fin_nxt.seq_idx      = sidx_nxt;
    fin_nxt.gap_count    = gap_nxt;
  end

  // Text state registers; cleared at the end of each text.
  always_ff @(posedge clk) begin
    if (!rst_n || ends) begin
      count_r  <= '0;
      prefix_r <= 1'b1;
      found_r  <= 1'b0;
      start_r  <= '0;
      bound_r  <= 1'b0;
      sidx_r   <= '0;
      gap_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      prefix_r <= prefix_nxt;
      found_r  <= found_nxt;
      start_r  <= start_nxt;
      bound_r  <= bound_nxt;
      sidx_r   <= sidx_nxt;
      gap_r    <= gap_nxt;
    end
  end

  // Snapshot stage holding the final state of a finished text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (ends) begin
      fin_valid_r <= 1'b1;
    end else if (fin_adv) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ends) begin
      fin_r <= fin_nxt;
    end
  end

  fms_score u_score (
    .fin   (fin_r),
    .score (sc_score),
    .kind  (sc_kind)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      out_score_r <= sc_score;
      out_kind_r  <= sc_kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_score      = out_score_r;
  assign out_match_kind = out_kind_r;

endmodule
